// ===== rtl/core/positional_array_list_assert.svh =====
// ----------------------------------------------------------------------------
// Positional array list assertion macros
// Concurrent check macros shared by the list RTL; empty when NO_ASSERTIONS set.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define PAL_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("positional_array_list: check failed");

// Next-cycle implication, disabled while reset is asserted
`define PAL_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("positional_array_list: check failed");

`else

`define PAL_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PAL_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional array list package
// Word types, operation and status codes, and control types for the cell row.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int LEN_W     = 8;
    localparam int DEPTH_DEF = 128;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_APPEND = 2'd1,
        OP_ERASE  = 2'd2,
        OP_READ   = 2'd3
    } pal_op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_BADPOS = 2'd2
    } pal_status_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } pal_state_t;

    typedef struct packed {
        pal_op_t                   opcode;
        logic [POS_W-1:0]          position;
        logic signed [DATA_W-1:0]  value;
    } pal_in_t;

    typedef struct packed {
        pal_status_t               status;
        logic signed [DATA_W-1:0]  read_value;
        logic [LEN_W-1:0]          length;
        logic                      is_empty;
    } pal_out_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic ins;       // shift up above the index, write the value at it
        logic era;       // shift down from the index
        logic rd_load;   // capture the entry at the index into its carry
        logic rd_shift;  // move carries one cell toward the head
    } pal_cell_ctrl_t;

endpackage

// ===== rtl/core/pal_cell.sv =====
// ----------------------------------------------------------------------------
// Positional array list cell
// Holds one list entry and one read carry; trades data with both neighbors.
// ----------------------------------------------------------------------------
module pal_cell #(
    parameter int IDX_W = 7,
    parameter int INDEX = 0
) (
    input  logic                               aclk,
    input  pal_pkg::pal_cell_ctrl_t            cell_ctrl,
    input  logic [IDX_W-1:0]                   cell_idx,
    input  logic signed [pal_pkg::DATA_W-1:0]  wr_value,
    input  logic signed [pal_pkg::DATA_W-1:0]  left_entry,
    input  logic signed [pal_pkg::DATA_W-1:0]  right_entry,
    input  logic signed [pal_pkg::DATA_W-1:0]  right_carry,
    output logic signed [pal_pkg::DATA_W-1:0]  entry,
    output logic signed [pal_pkg::DATA_W-1:0]  carry
);
    import pal_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] entry_reg, entry_next;
    logic signed [DATA_W-1:0] carry_reg, carry_next;

    // Pick the entry: write at the index, shift above it, or shift down on erase
    always_comb begin
        entry_next = entry_reg;
        if (cell_ctrl.ins) begin
            if (MY_IDX == cell_idx) begin
                entry_next = wr_value;
            end else if (MY_IDX > cell_idx) begin
                entry_next = left_entry;
            end
        end else if (cell_ctrl.era && (MY_IDX >= cell_idx)) begin
            entry_next = right_entry;
        end
    end

    // Load the addressed entry, then advance it toward the head
    always_comb begin
        carry_next = carry_reg;
        if (cell_ctrl.rd_load && (MY_IDX == cell_idx)) begin
            carry_next = entry_reg;
        end else if (cell_ctrl.rd_shift) begin
            carry_next = right_carry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        carry_reg <= carry_next;
    end

    assign entry = entry_reg;
    assign carry = carry_reg;

endmodule

// ===== rtl/core/pal_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional array list control
// Checks positions, keeps the count, drives the cell row and the result word.
// ----------------------------------------------------------------------------
module pal_ctrl #(
    parameter int DEPTH = pal_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  pal_pkg::pal_in_t                   s_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output pal_pkg::pal_out_t                  m_word,
    output pal_pkg::pal_cell_ctrl_t            cell_ctrl,
    output logic [IDX_W-1:0]                   cell_idx,
    input  logic signed [pal_pkg::DATA_W-1:0]  head_carry
);
    import pal_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    pal_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  walk_reg, walk_next;
    logic              m_valid_reg, m_valid_next;
    pal_out_t          m_word_reg, m_word_next;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              list_full;
    logic              pos_ok_ins;
    logic              pos_ok_rd;
    logic              out_free;
    logic              accept;
    logic [POS_W-1:0]  pos_m1;

    // Position and fill checks
    assign pos_ext    = CMP_W'(s_word.position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign list_full  = (cnt_ext == CMP_W'(DEPTH));
    assign pos_ok_ins = (s_word.position != '0) && (pos_ext <= (cnt_ext + CMP_W'(1)));
    assign pos_ok_rd  = (s_word.position != '0) && (pos_ext <= cnt_ext);
    assign pos_m1     = s_word.position - POS_W'(1);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // Decode the word, step the count, walk reads down the carry chain
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        walk_next    = walk_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cell_ctrl    = '0;
        cell_idx     = IDX_W'(pos_m1);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_valid_next           = 1'b1;
                    m_word_next.status     = STAT_OK;
                    m_word_next.read_value = '0;
                    unique case (s_word.opcode)
                        OP_INSERT: begin
                            priority if (list_full) begin
                                m_word_next.status = STAT_FULL;
                            end else if (!pos_ok_ins) begin
                                m_word_next.status = STAT_BADPOS;
                            end else begin
                                cell_ctrl.ins = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_APPEND: begin
                            if (list_full) begin
                                m_word_next.status = STAT_FULL;
                            end else begin
                                cell_ctrl.ins = 1'b1;
                                cell_idx      = IDX_W'(count_reg);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_ERASE: begin
                            if (!pos_ok_rd) begin
                                m_word_next.status = STAT_BADPOS;
                            end else begin
                                cell_ctrl.era = 1'b1;
                                count_next    = count_reg - CNT_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (!pos_ok_rd) begin
                                m_word_next.status = STAT_BADPOS;
                            end else begin
                                // hold the result until the entry reaches the head
                                cell_ctrl.rd_load = 1'b1;
                                walk_next         = pos_m1;
                                m_valid_next      = 1'b0;
                                state_next        = S_READ;
                            end
                        end
                    endcase
                    m_word_next.length   = LEN_W'(count_next);
                    m_word_next.is_empty = (count_next == '0);
                end
            end
            S_READ: begin
                if (walk_reg != '0) begin
                    cell_ctrl.rd_shift = 1'b1;
                    walk_next          = walk_reg - POS_W'(1);
                end else if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_word_next.status     = STAT_OK;
                    m_word_next.read_value = head_carry;
                    m_word_next.length     = LEN_W'(count_reg);
                    m_word_next.is_empty   = (count_reg == '0);
                    state_next             = S_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== rtl/core/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// Positional array list
// Ordered list of signed words held in a row of cells, one entry per cell.
//
//   Channel  Ports                       Word
//   input    s_valid, s_ready, s_word    opcode, position, value
//   result   m_valid, m_ready, m_word    status, read_value, length, is_empty
//
// Insert, append, erase and every rejected operation need no walk: all
// cells shift in parallel, so such words may follow each other every cycle
// while results are taken. A successful read at position p loads the entry
// into its cell's carry, and it walks one cell per cycle down to the head.
// Reset (aresetn low, synchronous) empties the list at once; entries are not
// cleared. A stalled result holds the input side once the output register
// is full.
// ----------------------------------------------------------------------------
`include "positional_array_list_assert.svh"

module positional_array_list #(
    parameter int DEPTH = pal_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pal_pkg::pal_in_t   s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output pal_pkg::pal_out_t  m_word
);
    import pal_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    pal_cell_ctrl_t            cell_ctrl;
    logic [IDX_W-1:0]          cell_idx;
    logic signed [DATA_W-1:0]  entry_w [DEPTH];
    logic signed [DATA_W-1:0]  carry_w [DEPTH];

    // Control and result register
    pal_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .cell_ctrl  (cell_ctrl),
        .cell_idx   (cell_idx),
        .head_carry (carry_w[0])
    );

    // Row of cells, head at index zero
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_entry;
        logic signed [DATA_W-1:0] right_entry;
        logic signed [DATA_W-1:0] right_carry;

        if (i == 0) begin : g_head
            assign left_entry = '0;
        end else begin : g_body
            assign left_entry = entry_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_entry = '0;
            assign right_carry = '0;
        end else begin : g_inner
            assign right_entry = entry_w[i+1];
            assign right_carry = carry_w[i+1];
        end

        pal_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .cell_ctrl   (cell_ctrl),
            .cell_idx    (cell_idx),
            .wr_value    (s_word.value),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .right_carry (right_carry),
            .entry       (entry_w[i]),
            .carry       (carry_w[i])
        );
    end

    // Checks
    `PAL_ASSERT_IMP(a_no_accept_in_walk, aclk, aresetn, cell_ctrl.rd_shift, !s_ready)
    `PAL_ASSERT_IMP(a_one_shift_kind, aclk, aresetn, cell_ctrl.ins, !cell_ctrl.era)
    `PAL_ASSERT_NXT(a_read_blocks, aclk, aresetn, cell_ctrl.rd_load, !s_ready)
    `PAL_ASSERT_NXT(a_quick_result, aclk, aresetn, s_valid && s_ready && !cell_ctrl.rd_load, m_valid)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// A table of directed words runs first, from an empty list through every
// opcode and position edge. Random traffic follows: one pass fills the list
// to full and empties it again, then mixed rounds grow or shrink the list.
// Both channels see random gaps and stalls, with some rounds running
// back to back. A local copy of the list predicts every result word.
// ----------------------------------------------------------------------------
module tb_top;
    import pal_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int N_DIR        = 25;
    localparam int N_RANDOM     = 900;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        pal_op_t     op;
        logic [7:0]  pos;
        logic [31:0] val;
        bit          typed;
        pal_status_t st;
        logic [31:0] rd;
        logic [7:0]  len;
        bit          emp;
    } dir_row_t;

    typedef struct {
        pal_out_t    res;
        int unsigned stamp;
    } pending_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pal_in_t  s_word  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pal_out_t m_word;

    // Local copy of the list
    logic signed [31:0] list_mem [DEPTH];
    int                 list_len = 0;

    pending_t    pending_results[$];
    int unsigned cyc_cnt   = 0;
    int          err_count = 0;
    int          n_sent    = 0;
    int          n_ok      = 0;
    int          n_full    = 0;
    int          n_bad     = 0;
    int          peak_len  = 0;
    bit          idle_off  = 1'b0;

    // Typed results only where they follow from the list contents at a glance
    dir_row_t dir_tab [N_DIR] = '{
        '{OP_READ,   8'd1,   32'd0,         1'b1, STAT_BADPOS, 32'd0,         8'd0, 1'b1},
        '{OP_ERASE,  8'd1,   32'd0,         1'b1, STAT_BADPOS, 32'd0,         8'd0, 1'b1},
        '{OP_INSERT, 8'd0,   32'd5,         1'b1, STAT_BADPOS, 32'd0,         8'd0, 1'b1},
        '{OP_INSERT, 8'd2,   32'd6,         1'b1, STAT_BADPOS, 32'd0,         8'd0, 1'b1},
        '{OP_INSERT, 8'd255, 32'd7,         1'b1, STAT_BADPOS, 32'd0,         8'd0, 1'b1},
        '{OP_INSERT, 8'd1,   32'h8000_0000, 1'b1, STAT_OK,     32'd0,         8'd1, 1'b0},
        '{OP_APPEND, 8'd255, 32'h7FFF_FFFF, 1'b1, STAT_OK,     32'd0,         8'd2, 1'b0},
        '{OP_READ,   8'd1,   32'hFFFF_FFFF, 1'b1, STAT_OK,     32'h8000_0000, 8'd2, 1'b0},
        '{OP_READ,   8'd2,   32'd0,         1'b1, STAT_OK,     32'h7FFF_FFFF, 8'd2, 1'b0},
        '{OP_READ,   8'd3,   32'd0,         1'b1, STAT_BADPOS, 32'd0,         8'd2, 1'b0},
        '{OP_INSERT, 8'd3,   32'hFFFF_FFFF, 1'b1, STAT_OK,     32'd0,         8'd3, 1'b0},
        '{OP_INSERT, 8'd2,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_READ,   8'd2,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_READ,   8'd3,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_READ,   8'd4,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_ERASE,  8'd0,   32'd0,         1'b1, STAT_BADPOS, 32'd0,         8'd4, 1'b0},
        '{OP_ERASE,  8'd5,   32'd0,         1'b1, STAT_BADPOS, 32'd0,         8'd4, 1'b0},
        '{OP_ERASE,  8'd1,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_READ,   8'd1,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_ERASE,  8'd3,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_READ,   8'd255, 32'd0,         1'b1, STAT_BADPOS, 32'd0,         8'd2, 1'b0},
        '{OP_APPEND, 8'd0,   32'h5555_5555, 1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_ERASE,  8'd1,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_ERASE,  8'd1,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0},
        '{OP_ERASE,  8'd1,   32'd0,         1'b0, STAT_OK,     32'd0,         8'd0, 1'b0}
    };

    positional_array_list #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Count cycles and stop a hung run
    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cyc_cnt, pending_results.size());
            $display("positional_array_list verification failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pal_in_t mk(pal_op_t op, int pos, logic [31:0] val);
        pal_in_t w;
        w.opcode   = op;
        w.position = 8'(pos);
        w.value    = val;
        return w;
    endfunction

    // Apply one word to the local list and return the result it should give
    function automatic pal_out_t list_apply(pal_in_t w);
        pal_out_t r;
        int       p;
        r = '0;
        p = int'(w.position);
        case (w.opcode)
            OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (int j = list_len; j > p - 1; j--) list_mem[j] = list_mem[j - 1];
                    list_mem[p - 1] = w.value;
                    list_len++;
                end
            end
            OP_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    list_mem[list_len] = w.value;
                    list_len++;
                end
            end
            OP_ERASE: begin
                if (p < 1 || p > list_len) begin
                    r.status = STAT_BADPOS;
                end else begin
                    for (int j = p - 1; j + 1 < list_len; j++) list_mem[j] = list_mem[j + 1];
                    list_len--;
                end
            end
            default: begin
                if (p < 1 || p > list_len) r.status = STAT_BADPOS;
                else r.read_value = list_mem[p - 1];
            end
        endcase
        r.length   = 8'(list_len);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    // Present one word, hold it until accepted, then queue its result
    task automatic issue(pal_in_t w, bit typed, pal_out_t typed_res);
        int       gap;
        pal_out_t pred;
        pending_t ent;
        gap = idle_off ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred      = list_apply(w);
        ent.res   = typed ? typed_res : pred;
        ent.stamp = cyc_cnt;
        pending_results.push_back(ent);
        case (pred.status)
            STAT_OK:   n_ok++;
            STAT_FULL: n_full++;
            default:   n_bad++;
        endcase
        if (list_len > peak_len) peak_len = list_len;
        n_sent++;
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH cycle %0d: %s", cyc_cnt, msg);
        err_count++;
    endtask

    // Result side: random stalls, or always ready in back-to-back rounds
    initial begin
        @(posedge aclk);
        forever begin
            if (idle_off) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                int n;
                n = gap_len();
                if (n > 0) begin
                    m_ready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // Compare each result word with the oldest pending one
    always @(posedge aclk) begin : result_check
        pending_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0 || pending_results[0].stamp >= cyc_cnt) begin
                report_mismatch("result word with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (m_word.status !== want.res.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_word.status, want.res.status));
                if (m_word.read_value !== want.res.read_value)
                    report_mismatch($sformatf("read_value got %h want %h",
                                              m_word.read_value, want.res.read_value));
                if (m_word.length !== want.res.length)
                    report_mismatch($sformatf("length got %0d want %0d",
                                              m_word.length, want.res.length));
                if (m_word.is_empty !== want.res.is_empty)
                    report_mismatch($sformatf("is_empty got %0d want %0d",
                                              m_word.is_empty, want.res.is_empty));
            end
        end
    end

    // Stimulus
    initial begin
        dir_row_t row;
        pal_out_t e;
        pal_op_t  op;
        int       pos;
        int       r;
        bit       grow;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < N_DIR; i++) begin
            row          = dir_tab[i];
            e            = '0;
            e.status     = row.st;
            e.read_value = row.rd;
            e.length     = row.len;
            e.is_empty   = row.emp;
            issue(mk(row.op, row.pos, row.val), row.typed, e);
        end

        // Fill to full, mostly by append with some inserts
        while (list_len < DEPTH) begin
            if ($urandom_range(0, 9) == 0)
                issue(mk(OP_INSERT, $urandom_range(1, list_len + 1), $urandom), 1'b0, '0);
            else
                issue(mk(OP_APPEND, $urandom_range(0, 255), $urandom), 1'b0, '0);
        end

        // Probe the full list: full wins over a bad insert position
        issue(mk(OP_INSERT, 1, $urandom), 1'b0, '0);
        issue(mk(OP_INSERT, DEPTH + 1, $urandom), 1'b0, '0);
        issue(mk(OP_INSERT, 0, $urandom), 1'b0, '0);
        issue(mk(OP_APPEND, 0, $urandom), 1'b0, '0);
        issue(mk(OP_READ, DEPTH, 0), 1'b0, '0);
        issue(mk(OP_READ, DEPTH + 1, 0), 1'b0, '0);
        issue(mk(OP_ERASE, DEPTH + 1, 0), 1'b0, '0);

        // Drain to empty with reads mixed in
        while (list_len > 0) begin
            if ($urandom_range(0, 4) == 0)
                issue(mk(OP_READ, $urandom_range(1, list_len), $urandom), 1'b0, '0);
            else
                issue(mk(OP_ERASE, $urandom_range(1, list_len), $urandom), 1'b0, '0);
        end
        issue(mk(OP_READ, 1, 0), 1'b0, '0);
        issue(mk(OP_ERASE, 1, 0), 1'b0, '0);
        issue(mk(OP_INSERT, 2, $urandom), 1'b0, '0);

        // Mixed rounds, each biased to grow or shrink the list
        while (n_sent < N_DIR + N_RANDOM) begin
            idle_off = ($urandom_range(0, 3) == 0);
            grow     = (list_len < $urandom_range(4, 60));
            for (int k = 0; k < 30; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    issue(mk(pal_op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                             $urandom), 1'b0, '0);
                end else begin
                    r = $urandom_range(0, 99);
                    if (grow)
                        op = (r < 35) ? OP_INSERT : (r < 55) ? OP_APPEND :
                             (r < 70) ? OP_ERASE : OP_READ;
                    else
                        op = (r < 12) ? OP_INSERT : (r < 20) ? OP_APPEND :
                             (r < 65) ? OP_ERASE : OP_READ;
                    case (op)
                        OP_INSERT: pos = $urandom_range(1, list_len + 1);
                        OP_APPEND: pos = $urandom_range(0, 255);
                        default:   pos = (list_len > 0) ? $urandom_range(1, list_len)
                                                        : $urandom_range(0, 255);
                    endcase
                    issue(mk(op, pos, $urandom), 1'b0, '0);
                end
            end
        end

        // Drop valid and let the last results drain
        s_valid <= 1'b0;
        idle_off = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d words: %0d ok, %0d full, %0d bad position",
                 n_sent, n_ok, n_full, n_bad);
        $display("list reached %0d of %0d entries; %0d mismatches",
                 peak_len, DEPTH, err_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("positional_array_list verification clean");
        end else begin
            $display("positional_array_list verification failed");
        end
        $finish;
    end

endmodule
